[hdl/psu_pkg.sv]
// psu_pkg: shared types and constants of the particle swarm update engine
// no dependencies
`default_nettype none
package psu_pkg;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_MOVE    = 2'd1,
        CMD_FITNESS = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_CPY,
        ST_OUT
    } state_t;

    localparam logic [1:0]  REG_C1    = 2'd0;
    localparam logic [1:0]  REG_C2    = 2'd1;
    localparam logic [1:0]  REG_VLIM  = 2'd2;
    localparam logic [31:0] COST_MAX  = 32'h7fff_ffff;
    localparam logic [15:0] C1_RESET  = 16'd8192;
    localparam logic [15:0] C2_RESET  = 16'd8192;
    localparam logic [30:0] VLIM_RESET = 31'd131072;

endpackage
`default_nettype wire

[hdl/particle_swarm_update.sv]
// particle_swarm_update: top level of the particle swarm update engine
// depends on psu_pkg; holds the element memories and the move datapath
//
// One request at a time. From acceptance to out_valid: an init, an ignored
// request or a fitness report that does not improve is latched, then gives its result.
// A move passes memory read, operand stage with the inertia product, attraction
// products, sum, clamp with position saturate and write-back, then result. A
// fitness report that improves also copies the position into the personal
// best, one memory word per cycle through its own read port, writing each word
// behind its registered read. Results sit in an output register. The next
// request is taken in the cycle after the result drains.
`default_nettype none
module particle_swarm_update #(
    parameter int PARTICLES  = 32,
    parameter int DIMENSIONS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [4:0]  particle,
    input  wire logic [2:0]  dimension,
    input  wire logic signed [31:0] value,
    input  wire logic [15:0] inertia,
    input  wire logic [15:0] rand_cognitive,
    input  wire logic [15:0] rand_social,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] new_position,
    output logic             improved,
    output logic [4:0]       best_particle,
    output logic signed [31:0] best_fitness
);
    import psu_pkg::*;

    localparam int PW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int DW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int AW = PW + DW;
    localparam int DEPTH = PARTICLES * DIMENSIONS;

    // element memories
    logic [31:0] pos_mem   [DEPTH];
    logic [31:0] vel_mem   [DEPTH];
    logic [31:0] pbest_mem [DEPTH];
    // per particle cost with valid bits
    logic [31:0] cost_mem  [PARTICLES];
    logic [PARTICLES-1:0] cost_vld_reg;

    state_t state_reg, state_next;
    logic [15:0] c1_reg, c2_reg;
    logic [30:0] vlim_reg;
    logic [PW-1:0] gbest_reg;

    // latched request
    cmd_t        cmd_reg;
    logic [PW-1:0] p_reg;
    logic [DW-1:0] d_reg;
    logic signed [31:0] val_reg;
    logic [15:0] w_reg, r1_reg, r2_reg;
    logic [DW:0] cnt_reg;

    // memory read data
    logic signed [31:0] x_rd, v_rd, pb_rd, gb_rd, cp_rd;

    // pipeline
    logic signed [31:0] k1_reg, k2_reg;
    logic signed [32:0] d1_reg, d2_reg;
    logic signed [63:0] t0_reg, t1_reg, t2_reg;
    logic signed [39:0] vs_reg;
    logic signed [31:0] vc_val, np_val;
    logic signed [32:0] np_sum;

    logic        imp_reg;
    logic signed [31:0] res_pos_reg;
    logic        ov_reg;

    // cost lookup, unwritten entries read as max
    function automatic logic [31:0] cost_of(input logic [PW-1:0] i,
                                            input logic [PARTICLES-1:0] vld,
                                            input logic [31:0] c);
        cost_of = vld[i] ? c : COST_MAX;
    endfunction

    logic [31:0] cost_p, cost_g;
    assign cost_p = cost_of(p_reg, cost_vld_reg, cost_mem[p_reg]);
    assign cost_g = cost_of(gbest_reg, cost_vld_reg, cost_mem[gbest_reg]);

    logic in_ok;
    logic [AW-1:0] e_addr, g_addr, c_addr;
    assign in_ok = (32'(particle) < PARTICLES)
        && ((cmd == CMD_FITNESS) || (32'(dimension) < DIMENSIONS));
    assign e_addr = AW'(32'(p_reg) * DIMENSIONS + 32'(d_reg));
    assign g_addr = AW'(32'(gbest_reg) * DIMENSIONS + 32'(d_reg));
    assign c_addr = AW'(32'(p_reg) * DIMENSIONS + 32'(cnt_reg[DW-1:0]));

    assign in_ready  = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign new_position = res_pos_reg;
    assign improved = imp_reg;
    assign best_particle = 5'(gbest_reg);
    assign best_fitness = cost_g;

    logic signed [31:0] lim_s;
    assign lim_s = {1'b0, vlim_reg};

    // velocity clamp and position saturate
    always_comb
    begin
        if (vs_reg > 40'(lim_s)) vc_val = lim_s;
        else if (vs_reg < -40'(lim_s)) vc_val = -lim_s;
        else vc_val = 32'(vs_reg);
        np_sum = 33'(x_rd) + 33'(vc_val);
        if (np_sum > 33'sh07fffffff) np_val = 32'sh7fffffff;
        else if (np_sum < -33'sh080000000) np_val = 32'sh80000000;
        else np_val = 32'(np_sum);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid && in_ready) state_next = ST_RD;
            ST_RD:
            begin
                case (cmd_reg)
                    CMD_MOVE: state_next = ST_M1;
                    CMD_FITNESS:
                        state_next = ($signed(val_reg) < $signed(cost_p)) ? ST_CPY : ST_OUT;
                    default: state_next = ST_OUT;
                endcase
            end
            ST_M1: state_next = ST_M2;
            ST_M2: state_next = ST_M3;
            ST_M3: state_next = ST_M4;
            ST_M4: state_next = ST_OUT;
            ST_CPY: if (32'(cnt_reg) == DIMENSIONS) state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration, control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= C1_RESET;
            c2_reg <= C2_RESET;
            vlim_reg <= VLIM_RESET;
            gbest_reg <= '0;
            cost_vld_reg <= '0;
            ov_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_C1:   c1_reg <= cfg_data[15:0];
                    REG_C2:   c2_reg <= cfg_data[15:0];
                    REG_VLIM: vlim_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            if (state_reg == ST_OUT) ov_reg <= 1'b1;
            if (state_reg == ST_RD)
            begin
                cnt_reg <= '0;
                if (cmd_reg == CMD_FITNESS && $signed(val_reg) < $signed(cost_p))
                begin
                    if ($signed(val_reg) < $signed(cost_g)) gbest_reg <= p_reg;
                    cost_vld_reg[p_reg] <= 1'b1;
                end
            end
            if (state_reg == ST_CPY) cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // request capture, datapath and memories
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && in_ready)
        begin
            cmd_reg <= in_ok ? cmd_t'(cmd) : CMD_NONE;
            p_reg <= PW'(particle);
            d_reg <= DW'(dimension);
            val_reg <= value;
            w_reg <= inertia;
            r1_reg <= rand_cognitive;
            r2_reg <= rand_social;
            imp_reg <= 1'b0;
            res_pos_reg <= '0;
        end
        // registered reads of the addressed, global best and copy elements
        x_rd  <= pos_mem[e_addr];
        v_rd  <= vel_mem[e_addr];
        pb_rd <= pbest_mem[e_addr];
        gb_rd <= pbest_mem[g_addr];
        cp_rd <= pos_mem[c_addr];
        if (state_reg == ST_RD)
        begin
            case (cmd_reg)
                CMD_INIT:
                begin
                    pos_mem[e_addr] <= val_reg;
                    vel_mem[e_addr] <= '0;
                    res_pos_reg <= val_reg;
                end
                CMD_FITNESS:
                    if ($signed(val_reg) < $signed(cost_p))
                    begin
                        cost_mem[p_reg] <= val_reg;
                        imp_reg <= 1'b1;
                    end
                default: ;
            endcase
        end
        // copy pipeline: read issued at cnt, written at cnt-1
        if (state_reg == ST_CPY && cnt_reg != '0)
            pbest_mem[AW'(32'(p_reg) * DIMENSIONS + 32'(cnt_reg) - 1)] <= cp_rd;
        // move stage 1: gains, differences and inertia product
        if (state_reg == ST_M1)
        begin
            k1_reg <= $signed({16'd0, 16'((32'(c1_reg) * 32'(r1_reg)) >> 16)});
            k2_reg <= $signed({16'd0, 16'((32'(c2_reg) * 32'(r2_reg)) >> 16)});
            d1_reg <= 33'(pb_rd) - 33'(x_rd);
            d2_reg <= 33'(gb_rd) - 33'(x_rd);
            t0_reg <= ($signed({1'b0, w_reg}) * 64'(v_rd)) >>> 16;
        end
        // move stage 2: attraction products
        if (state_reg == ST_M2)
        begin
            t1_reg <= (64'(k1_reg) * 64'(d1_reg)) >>> 12;
            t2_reg <= (64'(k2_reg) * 64'(d2_reg)) >>> 12;
        end
        // move stage 3: sum
        if (state_reg == ST_M3)
            vs_reg <= 40'(t0_reg) + 40'(t1_reg) + 40'(t2_reg);
        // move stage 4: write back clamped velocity and saturated position
        if (state_reg == ST_M4)
        begin
            vel_mem[e_addr] <= vc_val;
            pos_mem[e_addr] <= np_val;
            res_pos_reg <= np_val;
        end
    end

endmodule
`default_nettype wire

[tb/tb_particle_swarm_update.sv]
// tb_particle_swarm_update: self-checking testbench for the particle swarm update engine
// depends on psu_pkg and particle_swarm_update; queue-fed driver, clocked monitor,
// in-bench predictor of the swarm state
`default_nettype none
module tb_particle_swarm_update;
    import psu_pkg::*;

    typedef struct {
        logic [1:0]         cmd;
        logic [4:0]         particle;
        logic [2:0]         dimension;
        logic signed [31:0] value;
        logic [15:0]        inertia;
        logic [15:0]        rand_cognitive;
        logic [15:0]        rand_social;
    } request_t;

    typedef struct {
        logic signed [31:0] new_position;
        logic               improved;
        logic [4:0]         best_particle;
        logic signed [31:0] best_fitness;
    } swarm_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic [4:0]         particle;
    logic [2:0]         dimension;
    logic signed [31:0] value;
    logic [15:0]        inertia;
    logic [15:0]        rand_cognitive;
    logic [15:0]        rand_social;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] new_position;
    logic               improved;
    logic [4:0]         best_particle;
    logic signed [31:0] best_fitness;

    request_t      pending_requests[$];
    swarm_result_t expected_results[$];
    int            mismatches;
    longint        cycle_count;
    int            hold_cycles;

    // mirror of the swarm state
    logic signed [31:0] pos_mem[256];
    logic signed [31:0] vel_mem[256];
    logic signed [31:0] pbest_mem[256];
    logic signed [31:0] pbest_cost[32];
    logic [4:0]         best_idx;
    logic [15:0]        c1_gain;
    logic [15:0]        c2_gain;
    logic [30:0]        vmax;
    // which elements are safe to read
    logic [7:0]         pos_written[32];
    logic               pbest_set[32];

    particle_swarm_update u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .particle       (particle),
        .dimension      (dimension),
        .value          (value),
        .inertia        (inertia),
        .rand_cognitive (rand_cognitive),
        .rand_social    (rand_social),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .new_position   (new_position),
        .improved       (improved),
        .best_particle  (best_particle),
        .best_fitness   (best_fitness)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // attraction toward a target, floor rounding
    function automatic longint attract(logic [15:0] gain, logic [15:0] rnd,
                                       logic signed [31:0] target,
                                       logic signed [31:0] x);
        longint k;
        longint diff;
        k = longint'((32'(gain) * 32'(rnd)) >> 16);
        diff = longint'(target) - longint'(x);
        return (k * diff) >>> 12;
    endfunction

    // apply one request to the mirror and return what the block should report
    function automatic swarm_result_t swarm_predict(request_t rq);
        swarm_result_t res;
        int            e;
        int            g;
        longint        v;
        longint        nx;
        longint        lim;
        res.new_position = '0;
        res.improved = 1'b0;
        e = int'(rq.particle) * 8 + int'(rq.dimension);
        g = int'(best_idx) * 8 + int'(rq.dimension);
        if (rq.cmd == CMD_INIT)
        begin
            pos_mem[e] = rq.value;
            vel_mem[e] = '0;
            res.new_position = rq.value;
        end
        else if (rq.cmd == CMD_MOVE)
        begin
            lim = longint'(vmax);
            v = (longint'(rq.inertia) * longint'(vel_mem[e])) >>> 16;
            v += attract(c1_gain, rq.rand_cognitive, pbest_mem[e], pos_mem[e]);
            v += attract(c2_gain, rq.rand_social, pbest_mem[g], pos_mem[e]);
            if (v < -lim)
                v = -lim;
            else if (v > lim)
                v = lim;
            vel_mem[e] = 32'(v);
            nx = longint'(pos_mem[e]) + v;
            if (nx > 64'sd2147483647)
                nx = 64'sd2147483647;
            else if (nx < -64'sd2147483648)
                nx = -64'sd2147483648;
            pos_mem[e] = 32'(nx);
            res.new_position = 32'(nx);
        end
        else if (rq.cmd == CMD_FITNESS)
        begin
            if (rq.value < pbest_cost[rq.particle])
            begin
                if (rq.value < pbest_cost[best_idx])
                    best_idx = rq.particle;
                for (int j = 0; j < 8; j++)
                    pbest_mem[int'(rq.particle) * 8 + j] = pos_mem[int'(rq.particle) * 8 + j];
                pbest_cost[rq.particle] = rq.value;
                res.improved = 1'b1;
            end
        end
        res.best_particle = best_idx;
        res.best_fitness = pbest_cost[best_idx];
        return res;
    endfunction

    // queue a request with its expected result, track what becomes readable
    task automatic push_request(logic [1:0] c, logic [4:0] p, logic [2:0] d,
                                logic signed [31:0] val, logic [15:0] w,
                                logic [15:0] r1, logic [15:0] r2);
        request_t rq;
        rq.cmd = c;
        rq.particle = p;
        rq.dimension = d;
        rq.value = val;
        rq.inertia = w;
        rq.rand_cognitive = r1;
        rq.rand_social = r2;
        expected_results.push_back(swarm_predict(rq));
        if (c == CMD_INIT)
            pos_written[p][d] = 1'b1;
        if (c == CMD_FITNESS && expected_results[$].improved)
            pbest_set[p] = 1'b1;
        pending_requests.push_back(rq);
    endtask

    // one random request that never reads an unwritten element
    task automatic random_request();
        int          pick;
        logic [4:0]  p;
        logic [2:0]  d;
        longint      cost;
        logic        found;
        pick = $urandom_range(0, 99);
        p = 5'($urandom);
        d = 3'($urandom);
        if (pick < 4)
        begin
            push_request(CMD_NONE, p, d, $urandom, 16'($urandom), 16'($urandom),
                         16'($urandom));
        end
        else if (pick < 55)
        begin
            found = 1'b0;
            for (int t = 0; t < 12 && !found; t++)
            begin
                if (pbest_set[p] && pos_written[p][d] && pbest_set[best_idx])
                    found = 1'b1;
                else
                begin
                    p = 5'($urandom);
                    d = 3'($urandom);
                end
            end
            if (found)
                push_request(CMD_MOVE, p, d, $urandom, 16'($urandom), 16'($urandom),
                             16'($urandom));
            else
                push_request(CMD_INIT, p, d, $urandom, 16'($urandom), 16'($urandom),
                             16'($urandom));
        end
        else if (pick < 78 && pos_written[p] == 8'hff)
        begin
            if ($urandom_range(0, 2) == 0)
                cost = longint'($signed(32'($urandom)));
            else
                cost = longint'(pbest_cost[p]) - $urandom_range(0, 3000);
            if (cost < -64'sd2147483648)
                cost = -64'sd2147483648;
            push_request(CMD_FITNESS, p, d, 32'(cost), 16'($urandom), 16'($urandom),
                         16'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                push_request(CMD_INIT, p, d, $urandom, 16'($urandom), 16'($urandom),
                             16'($urandom));
            else
                push_request(CMD_INIT, p, d, $signed(32'($urandom_range(0, 20'hfffff)))
                             - 32'sh80000, 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    // register write while the block is idle
    task automatic write_register(logic [1:0] idx, logic [30:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_C1)
            c1_gain = data[15:0];
        else if (idx == REG_C2)
            c2_gain = data[15:0];
        else if (idx == REG_VLIM)
            vmax = data;
    endtask

    task automatic wait_drained();
        wait (pending_requests.size() == 0 && expected_results.size() == 0 && !in_valid);
        repeat (20) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                void'(pending_requests.pop_front());
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() > 0 &&
                    (($urandom_range(0, 99) >= 11) || (cycle_count > 2000 && cycle_count < 5000)))
                begin
                    in_valid <= 1'b1;
                    cmd <= pending_requests[0].cmd;
                    particle <= pending_requests[0].particle;
                    dimension <= pending_requests[0].dimension;
                    value <= pending_requests[0].value;
                    inertia <= pending_requests[0].inertia;
                    rand_cognitive <= pending_requests[0].rand_cognitive;
                    rand_social <= pending_requests[0].rand_social;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cycles <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result at cycle %0d", cycle_count);
                end
                else
                begin
                    if (new_position !== expected_results[0].new_position ||
                        improved !== expected_results[0].improved ||
                        best_particle !== expected_results[0].best_particle ||
                        best_fitness !== expected_results[0].best_fitness)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("result mismatch at cycle %0d: exp %h %b %0d %h got %h %b %0d %h",
                                     cycle_count, expected_results[0].new_position,
                                     expected_results[0].improved,
                                     expected_results[0].best_particle,
                                     expected_results[0].best_fitness,
                                     new_position, improved, best_particle, best_fitness);
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (cycle_count == 6000)
                hold_cycles <= 400;
            else if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            if (hold_cycles > 1 || cycle_count == 6000)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(0, 99) >= 11) ||
                             (cycle_count > 2000 && cycle_count < 5000);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd = '0;
        particle = '0;
        dimension = '0;
        value = '0;
        inertia = '0;
        rand_cognitive = '0;
        rand_social = '0;
        mismatches = 0;
        cycle_count = 0;
        best_idx = '0;
        c1_gain = C1_RESET;
        c2_gain = C2_RESET;
        vmax = VLIM_RESET;
        for (int i = 0; i < 256; i++)
        begin
            pos_mem[i] = '0;
            vel_mem[i] = '0;
            pbest_mem[i] = '0;
        end
        for (int i = 0; i < 32; i++)
        begin
            pbest_cost[i] = COST_MAX;
            pos_written[i] = '0;
            pbest_set[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme positions, cost ties, unused command, extreme moves
        push_request(CMD_INIT, 5'd0, 3'd0, 32'sh7fffffff, 16'h0, 16'h0, 16'h0);
        push_request(CMD_INIT, 5'd0, 3'd1, 32'sh80000000, 16'hffff, 16'hffff, 16'hffff);
        push_request(CMD_INIT, 5'd0, 3'd2, 32'sd0, 16'h0, 16'h0, 16'h0);
        push_request(CMD_INIT, 5'd0, 3'd3, -32'sd1, 16'h0, 16'h0, 16'h0);
        push_request(CMD_INIT, 5'd0, 3'd4, 32'sh10000, 16'h0, 16'h0, 16'h0);
        push_request(CMD_INIT, 5'd0, 3'd5, -32'sh10000, 16'h0, 16'h0, 16'h0);
        push_request(CMD_INIT, 5'd0, 3'd6, $urandom, 16'h0, 16'h0, 16'h0);
        push_request(CMD_INIT, 5'd0, 3'd7, $urandom, 16'h0, 16'h0, 16'h0);
        push_request(CMD_FITNESS, 5'd0, 3'd7, 32'sd100, 16'h0, 16'h0, 16'h0);
        push_request(CMD_FITNESS, 5'd0, 3'd0, 32'sd100, 16'h0, 16'h0, 16'h0);
        push_request(CMD_NONE, 5'd31, 3'd7, 32'sh7fffffff, 16'hffff, 16'hffff, 16'hffff);
        push_request(CMD_MOVE, 5'd0, 3'd0, 32'sd0, 16'hffff, 16'hffff, 16'hffff);
        push_request(CMD_MOVE, 5'd0, 3'd1, 32'sd0, 16'h0, 16'h0, 16'h0);
        push_request(CMD_MOVE, 5'd0, 3'd1, 32'sd0, 16'hffff, 16'hffff, 16'h0);
        push_request(CMD_FITNESS, 5'd0, 3'd0, 32'sh80000000, 16'h0, 16'h0, 16'h0);
        for (int j = 0; j < 8; j++)
            push_request(CMD_INIT, 5'd31, 3'(j), $urandom, 16'h0, 16'h0, 16'h0);
        push_request(CMD_FITNESS, 5'd31, 3'd0, 32'sh7fffffff, 16'h0, 16'h0, 16'h0);
        push_request(CMD_FITNESS, 5'd31, 3'd0, 32'sd5, 16'h0, 16'h0, 16'h0);

        // random phases; each later phase first rewrites the registers
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                case (ph)
                    1:
                    begin
                        write_register(REG_C1, 31'd0);
                        write_register(REG_C2, 31'd0);
                        write_register(REG_VLIM, 31'd0);
                    end
                    2:
                    begin
                        write_register(REG_C1, 31'hffff);
                        write_register(REG_C2, 31'hffff);
                        write_register(REG_VLIM, 31'h7fffffff);
                    end
                    5:
                    begin
                        write_register(REG_C1, 31'(C1_RESET));
                        write_register(REG_C2, 31'(C2_RESET));
                        write_register(REG_VLIM, VLIM_RESET);
                    end
                    default:
                    begin
                        write_register(REG_C1, 31'($urandom_range(0, 16'hffff)));
                        write_register(REG_C2, 31'($urandom_range(0, 16'hffff)));
                        write_register(REG_VLIM, 31'($urandom));
                    end
                endcase
            end
            for (int n = 0; n < 290; n++)
                random_request();
        end

        wait_drained();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
